FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL; each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a property at the same edge.
`define ASSERT_IMPLIES(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Check that a condition implies a property at the following edge.
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: rtl/sbpm_pkg.sv
package sbpm_pkg;

  typedef enum logic [2:0] {
    FUNC_WRITE_POS  = 3'd0,
    FUNC_WRITE_REG  = 3'd1,
    FUNC_PING       = 3'd2,
    FUNC_SYNC_WRITE = 3'd3,
    FUNC_RX_BYTE    = 3'd4,
    FUNC_TICK       = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    CMD_POS     = 3'd0,
    CMD_REG     = 3'd1,
    CMD_PING    = 3'd2,
    CMD_SYNC    = 3'd3,
    CMD_OUTCOME = 3'd4
  } cmd_kind_t;

  typedef enum logic [2:0] {
    REG_TIMEOUT_TICKS = 3'd0,
    REG_WRITE_OPCODE  = 3'd1,
    REG_SYNC_OPCODE   = 3'd2,
    REG_PING_OPCODE   = 3'd3,
    REG_GOAL_REGISTER = 3'd4
  } reg_index_t;

  // One queued job: a packet to frame or a reply outcome to report.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  id;
    logic [7:0]  addr;
    logic [7:0]  data;      // write data, or the error byte of an outcome
    logic [15:0] pos;
    logic [7:0]  id2;
    logic [15:0] pos2;
    logic        timed_out;
  } cmd_t;

  typedef struct packed {
    logic [7:0] timeout_ticks;
    logic [7:0] write_opcode;
    logic [7:0] sync_opcode;
    logic [7:0] ping_opcode;
    logic [7:0] goal_register;
  } cfg_t;

  localparam logic [7:0] HDR_BYTE      = 8'hFF;
  localparam logic [7:0] BROADCAST_ID  = 8'hFE;
  localparam logic [7:0] PER_SERVO_LEN = 8'h02;
  localparam logic [7:0] LEN_POS       = 8'h05;
  localparam logic [7:0] LEN_REG       = 8'h04;
  localparam logic [7:0] LEN_PING      = 8'h02;
  localparam logic [7:0] LEN_SYNC      = 8'h0A;
  localparam logic [7:0] NO_ERROR_YET  = 8'hFF;

  localparam logic [2:0] ERROR_POS  = 3'd4;
  localparam logic [2:0] REPLY_LAST = 3'd5;

  // Index of the checksum byte within each packet
  localparam logic [3:0] LAST_POS  = 4'd8;
  localparam logic [3:0] LAST_REG  = 4'd7;
  localparam logic [3:0] LAST_PING = 4'd5;
  localparam logic [3:0] LAST_SYNC = 4'd13;

  localparam logic [7:0] RST_TIMEOUT_TICKS = 8'd250;
  localparam logic [7:0] RST_WRITE_OPCODE  = 8'd3;
  localparam logic [7:0] RST_SYNC_OPCODE   = 8'd131;
  localparam logic [7:0] RST_PING_OPCODE   = 8'd1;
  localparam logic [7:0] RST_GOAL_REGISTER = 8'd30;

endpackage

FILE: rtl/sbpm_front.sv
module sbpm_front (
  input  logic          clk,
  input  logic          rst,
  input  sbpm_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    func,
  input  logic [7:0]    servo_id,
  input  logic [7:0]    reg_addr,
  input  logic [7:0]    data_byte,
  input  logic [15:0]   position,
  input  logic [7:0]    second_id,
  input  logic [15:0]   second_position,
  input  logic [7:0]    rx_byte,
  input  logic          q_full,
  output logic          push,
  output sbpm_pkg::cmd_t push_cmd
);
  import sbpm_pkg::*;
  `include "assert_macros.svh"

  logic       awaiting, awaiting_next;
  logic [2:0] reply_count, reply_count_next;
  logic [7:0] tick_budget, tick_budget_next;
  logic [7:0] captured_error, captured_error_next;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    awaiting_next       = awaiting;
    reply_count_next    = reply_count;
    tick_budget_next    = tick_budget;
    captured_error_next = captured_error;
    push                = 1'b0;
    push_cmd.kind       = CMD_POS;
    push_cmd.id         = servo_id;
    push_cmd.addr       = reg_addr;
    push_cmd.data       = data_byte;
    push_cmd.pos        = position;
    push_cmd.id2        = second_id;
    push_cmd.pos2       = second_position;
    push_cmd.timed_out  = 1'b0;
    if (accept) begin
      unique case (func_t'(func)) inside
        FUNC_WRITE_POS, FUNC_WRITE_REG, FUNC_PING: begin
          if (!awaiting) begin
            push                = 1'b1;
            push_cmd.kind       = (func_t'(func) == FUNC_WRITE_POS) ? CMD_POS :
                                  (func_t'(func) == FUNC_WRITE_REG) ? CMD_REG : CMD_PING;
            awaiting_next       = 1'b1;
            reply_count_next    = 3'd0;
            tick_budget_next    = cfg.timeout_ticks;
            captured_error_next = NO_ERROR_YET;
          end
        end
        FUNC_SYNC_WRITE: begin
          if (!awaiting) begin
            push          = 1'b1;
            push_cmd.kind = CMD_SYNC;
          end
        end
        FUNC_RX_BYTE: begin
          if (awaiting) begin
            if (reply_count == ERROR_POS) captured_error_next = rx_byte;
            tick_budget_next = cfg.timeout_ticks;
            if (reply_count == REPLY_LAST) begin
              push             = 1'b1;
              push_cmd.kind    = CMD_OUTCOME;
              push_cmd.data    = captured_error;
              awaiting_next    = 1'b0;
              reply_count_next = 3'd0;
              tick_budget_next = 8'd0;
            end else begin
              reply_count_next = reply_count + 3'd1;
            end
          end
        end
        FUNC_TICK: begin
          if (awaiting) begin
            if (tick_budget <= 8'd1) begin
              push               = 1'b1;
              push_cmd.kind      = CMD_OUTCOME;
              push_cmd.data      = NO_ERROR_YET;
              push_cmd.timed_out = 1'b1;
              awaiting_next      = 1'b0;
              reply_count_next   = 3'd0;
              tick_budget_next   = 8'd0;
            end else begin
              tick_budget_next = tick_budget - 8'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting       <= 1'b0;
      reply_count    <= 3'd0;
      tick_budget    <= 8'd0;
      captured_error <= NO_ERROR_YET;
    end else begin
      awaiting       <= awaiting_next;
      reply_count    <= reply_count_next;
      tick_budget    <= tick_budget_next;
      captured_error <= captured_error_next;
    end
  end

  `ASSERT_IMPLIES(a_idle_count_zero, !awaiting, reply_count == 3'd0, "count set while idle")
  `ASSERT_ALWAYS(a_count_range, reply_count <= REPLY_LAST, "reply count past end")
  `ASSERT_NEXT(a_outcome_idles, push && push_cmd.kind == CMD_OUTCOME, !awaiting,
               "still awaiting after outcome")

endmodule

FILE: rtl/sbpm_queue.sv
module sbpm_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sbpm_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output sbpm_pkg::cmd_t head
);
  import sbpm_pkg::*;
  `include "assert_macros.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count <= CNT_FULL, "queue count overflow")
  `ASSERT_IMPLIES(a_no_push_full, push, !full, "push into full queue")
  `ASSERT_IMPLIES(a_no_pop_empty, pop, head_valid, "pop from empty queue")

endmodule

FILE: rtl/sbpm_back.sv
module sbpm_back (
  input  logic           clk,
  input  logic           rst,
  input  sbpm_pkg::cfg_t cfg,
  input  logic           head_valid,
  input  sbpm_pkg::cmd_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           kind,
  output logic [7:0]     tx_byte,
  output logic           last,
  output logic [7:0]     error_byte,
  output logic           timed_out
);
  import sbpm_pkg::*;
  `include "assert_macros.svh"

  logic [3:0] idx;
  logic [7:0] sum;
  logic [3:0] last_idx;
  logic [7:0] body;
  logic [7:0] cur_byte;
  logic       advance, emit, is_outcome, is_chk;

  function automatic logic [7:0] body_byte(cmd_t c, cfg_t g, logic [3:0] bi);
    logic [7:0] b;
    b = 8'h00;
    case (c.kind)
      CMD_POS: begin
        case (bi)
          4'd0:    b = c.id;
          4'd1:    b = LEN_POS;
          4'd2:    b = g.write_opcode;
          4'd3:    b = g.goal_register;
          4'd4:    b = c.pos[7:0];
          default: b = c.pos[15:8];
        endcase
      end
      CMD_REG: begin
        case (bi)
          4'd0:    b = c.id;
          4'd1:    b = LEN_REG;
          4'd2:    b = g.write_opcode;
          4'd3:    b = c.addr;
          default: b = c.data;
        endcase
      end
      CMD_PING: begin
        case (bi)
          4'd0:    b = c.id;
          4'd1:    b = LEN_PING;
          default: b = g.ping_opcode;
        endcase
      end
      CMD_SYNC: begin
        case (bi)
          4'd0:    b = BROADCAST_ID;
          4'd1:    b = LEN_SYNC;
          4'd2:    b = g.sync_opcode;
          4'd3:    b = g.goal_register;
          4'd4:    b = PER_SERVO_LEN;
          4'd5:    b = c.id;
          4'd6:    b = c.pos[7:0];
          4'd7:    b = c.pos[15:8];
          4'd8:    b = c.id2;
          4'd9:    b = c.pos2[7:0];
          default: b = c.pos2[15:8];
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  always_comb begin
    case (head.kind)
      CMD_POS:  last_idx = LAST_POS;
      CMD_REG:  last_idx = LAST_REG;
      CMD_PING: last_idx = LAST_PING;
      CMD_SYNC: last_idx = LAST_SYNC;
      default:  last_idx = 4'd0;
    endcase
  end

  assign is_outcome = (head.kind == CMD_OUTCOME);
  assign is_chk     = (idx == last_idx);
  assign body       = body_byte(head, cfg, idx - 4'd2);
  assign cur_byte   = (idx < 4'd2) ? HDR_BYTE : (is_chk ? ~sum : body);
  assign advance    = !out_valid || out_ready;
  assign emit       = advance && head_valid;
  assign pop        = emit && (is_outcome || is_chk);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 4'd0;
      sum       <= 8'd0;
    end else begin
      if (advance) out_valid <= head_valid;
      if (pop) begin
        idx <= 4'd0;
        sum <= 8'd0;
      end else if (emit) begin
        idx <= idx + 4'd1;
        if (idx >= 4'd2) sum <= sum + cur_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind       <= is_outcome;
      tx_byte    <= is_outcome ? 8'h00 : cur_byte;
      last       <= !is_outcome && is_chk;
      error_byte <= is_outcome ? head.data : 8'h00;
      timed_out  <= is_outcome && head.timed_out;
    end
  end

  `ASSERT_IMPLIES(a_mid_packet_head, idx != 4'd0, head_valid, "head lost mid packet")
  `ASSERT_IMPLIES(a_outcome_at_start, head_valid && is_outcome, idx == 4'd0,
                  "outcome inside a packet")
  `ASSERT_ALWAYS(a_idx_range, idx <= LAST_SYNC, "byte index past longest packet")

endmodule

FILE: rtl/servo_bus_packet_master.sv
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+------------------------------------------
// in       | input     | in_valid / in_ready  | func servo_id reg_addr data_byte position
//          |           |                      | second_id second_position rx_byte
// out      | output    | out_valid / out_ready| kind tx_byte last error_byte timed_out
// cfg      | input     | cfg_valid / cfg_ready| cfg_index cfg_data
//
// Each item is taken while the command queue has room; a request then yields one packet byte
// per cycle unless the output stalls, framed by the byte sequencer in the back end.
// Reply bytes and ticks are absorbed by the front; an outcome is one output item.
// Reset (rst, synchronous) empties the queue, drops any reply wait and restores
// the register defaults. A stalled output holds the sequencer; input stalls only
// once the command queue is full.
module servo_bus_packet_master #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [7:0]  servo_id,
  input  logic [7:0]  reg_addr,
  input  logic [7:0]  data_byte,
  input  logic [15:0] position,
  input  logic [7:0]  second_id,
  input  logic [15:0] second_position,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  tx_byte,
  output logic        last,
  output logic [7:0]  error_byte,
  output logic        timed_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import sbpm_pkg::*;

  cfg_t cfg;
  logic q_full, push, pop, head_valid;
  cmd_t push_cmd, head;

  // Register file: always ready, unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks <= RST_TIMEOUT_TICKS;
      cfg.write_opcode  <= RST_WRITE_OPCODE;
      cfg.sync_opcode   <= RST_SYNC_OPCODE;
      cfg.ping_opcode   <= RST_PING_OPCODE;
      cfg.goal_register <= RST_GOAL_REGISTER;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data;
        REG_WRITE_OPCODE:  cfg.write_opcode  <= cfg_data;
        REG_SYNC_OPCODE:   cfg.sync_opcode   <= cfg_data;
        REG_PING_OPCODE:   cfg.ping_opcode   <= cfg_data;
        REG_GOAL_REGISTER: cfg.goal_register <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: classify each item, track the reply wait, queue packets and outcomes.
  sbpm_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .func            (func),
    .servo_id        (servo_id),
    .reg_addr        (reg_addr),
    .data_byte       (data_byte),
    .position        (position),
    .second_id       (second_id),
    .second_position (second_position),
    .rx_byte         (rx_byte),
    .q_full          (q_full),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  // Queue: decouple the front from the byte sequencer.
  sbpm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: frame packets byte by byte with a running checksum.
  sbpm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .tx_byte    (tx_byte),
    .last       (last),
    .error_byte (error_byte),
    .timed_out  (timed_out)
  );

endmodule

FILE: tb/sv/sbpm_packet_checker.sv
module sbpm_packet_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  func,
  input  logic [7:0]  servo_id,
  input  logic [7:0]  reg_addr,
  input  logic [7:0]  data_byte,
  input  logic [15:0] position,
  input  logic [7:0]  second_id,
  input  logic [15:0] second_position,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        kind,
  input  logic [7:0]  tx_byte,
  input  logic        last,
  input  logic [7:0]  error_byte,
  input  logic        timed_out,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          pending,
  output logic        idle,
  output int          bytes_seen,
  output int          outcomes_seen,
  output int          timeouts_seen
);
  import sbpm_pkg::*;

  localparam logic [7:0] TIMEOUT_ERROR = 8'hFF;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic       last;
    logic [7:0] error_byte;
    logic       timed_out;
  } bus_result_t;

  bus_result_t frames_due [$];

  cfg_t       regs;
  logic       awaiting;
  logic [2:0] reply_seen;
  logic [7:0] budget;
  logic [7:0] held_error;
  logic [7:0] pkt_body [0:10];

  int mismatches = 0;
  int n_bytes    = 0;
  int n_outcomes = 0;
  int n_timeouts = 0;

  task automatic push_byte(input logic [7:0] b, input logic fin);
    frames_due.push_back({1'b0, b, fin, 8'h00, 1'b0});
  endtask

  // Frame the body with the header pair and the inverted sum of the body.
  task automatic frame_packet(input int n);
    logic [7:0] sum;
    sum = '0;
    push_byte(HDR_BYTE, 1'b0);
    push_byte(HDR_BYTE, 1'b0);
    for (int i = 0; i < n; i++) begin
      push_byte(pkt_body[i], 1'b0);
      sum = sum + pkt_body[i];
    end
    push_byte(~sum, 1'b1);
  endtask

  task automatic report_outcome(input logic [7:0] err, input logic late);
    frames_due.push_back({1'b1, 8'h00, 1'b0, err, late});
    awaiting   = 1'b0;
    reply_seen = '0;
    budget     = '0;
  endtask

  task automatic absorb_item();
    int n;
    n = 0;
    // Drop requests while a reply is still awaited.
    if (func <= FUNC_SYNC_WRITE && awaiting) return;
    case (func)
      FUNC_WRITE_POS: begin
        pkt_body[0] = servo_id;
        pkt_body[1] = LEN_POS;
        pkt_body[2] = regs.write_opcode;
        pkt_body[3] = regs.goal_register;
        pkt_body[4] = position[7:0];
        pkt_body[5] = position[15:8];
        n = 6;
      end
      FUNC_WRITE_REG: begin
        pkt_body[0] = servo_id;
        pkt_body[1] = LEN_REG;
        pkt_body[2] = regs.write_opcode;
        pkt_body[3] = reg_addr;
        pkt_body[4] = data_byte;
        n = 5;
      end
      FUNC_PING: begin
        pkt_body[0] = servo_id;
        pkt_body[1] = LEN_PING;
        pkt_body[2] = regs.ping_opcode;
        n = 3;
      end
      FUNC_SYNC_WRITE: begin
        pkt_body[0]  = BROADCAST_ID;
        pkt_body[1]  = LEN_SYNC;
        pkt_body[2]  = regs.sync_opcode;
        pkt_body[3]  = regs.goal_register;
        pkt_body[4]  = PER_SERVO_LEN;
        pkt_body[5]  = servo_id;
        pkt_body[6]  = position[7:0];
        pkt_body[7]  = position[15:8];
        pkt_body[8]  = second_id;
        pkt_body[9]  = second_position[7:0];
        pkt_body[10] = second_position[15:8];
        n = 11;
      end
      FUNC_RX_BYTE: begin
        if (awaiting) begin
          if (reply_seen == ERROR_POS) held_error = rx_byte;
          budget = regs.timeout_ticks;
          if (reply_seen == REPLY_LAST) report_outcome(held_error, 1'b0);
          else reply_seen = reply_seen + 3'd1;
        end
      end
      FUNC_TICK: begin
        if (awaiting) begin
          if (budget <= 8'd1) report_outcome(TIMEOUT_ERROR, 1'b1);
          else budget = budget - 8'd1;
        end
      end
      default: ;
    endcase
    if (n > 0) begin
      frame_packet(n);
      if (func != FUNC_SYNC_WRITE) begin
        awaiting   = 1'b1;
        reply_seen = '0;
        budget     = regs.timeout_ticks;
        held_error = NO_ERROR_YET;
      end
    end
  endtask

  task automatic check_result();
    bus_result_t got;
    bus_result_t want;
    got = {kind, tx_byte, last, error_byte, timed_out};
    if (got.kind) begin
      n_outcomes++;
      if (got.timed_out) n_timeouts++;
    end else begin
      n_bytes++;
    end
    if (frames_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] result with nothing due: kind=%0d tx_byte=%02h last=%0d err=%02h to=%0d",
                 $time, got.kind, got.tx_byte, got.last, got.error_byte, got.timed_out);
      return;
    end
    want = frames_due.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] mismatch: expected kind=%0d tx_byte=%02h last=%0d err=%02h to=%0d",
                 $time, want.kind, want.tx_byte, want.last, want.error_byte, want.timed_out);
        $display("[%0t]           actual   kind=%0d tx_byte=%02h last=%0d err=%02h to=%0d",
                 $time, got.kind, got.tx_byte, got.last, got.error_byte, got.timed_out);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs.timeout_ticks = RST_TIMEOUT_TICKS;
      regs.write_opcode  = RST_WRITE_OPCODE;
      regs.sync_opcode   = RST_SYNC_OPCODE;
      regs.ping_opcode   = RST_PING_OPCODE;
      regs.goal_register = RST_GOAL_REGISTER;
      awaiting   = 1'b0;
      reply_seen = '0;
      budget     = '0;
      held_error = NO_ERROR_YET;
      frames_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TIMEOUT_TICKS: regs.timeout_ticks = cfg_data;
          REG_WRITE_OPCODE:  regs.write_opcode  = cfg_data;
          REG_SYNC_OPCODE:   regs.sync_opcode   = cfg_data;
          REG_PING_OPCODE:   regs.ping_opcode   = cfg_data;
          REG_GOAL_REGISTER: regs.goal_register = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) absorb_item();
      if (out_valid && out_ready) check_result();
    end
    fail_count    <= mismatches;
    pending       <= frames_due.size();
    idle          <= (frames_due.size() == 0) && !awaiting;
    bytes_seen    <= n_bytes;
    outcomes_seen <= n_outcomes;
    timeouts_seen <= n_timeouts;
  end

endmodule

FILE: tb/sv/tb.sv
module tb;
  import sbpm_pkg::*;

  // One item on the request channel, in port order.
  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  id;
    logic [7:0]  addr;
    logic [7:0]  dat;
    logic [15:0] pos;
    logic [7:0]  id2;
    logic [15:0] pos2;
    logic [7:0]  rx;
  } bus_item_t;

  // Ways the result side takes bytes off the block.
  typedef enum logic [1:0] {
    DRAIN_FREE,
    DRAIN_COIN,
    DRAIN_SPARSE,
    DRAIN_RUNS
  } drain_mode_t;

  // Function codes the block leaves undefined, and a register index past the last one.
  localparam logic [2:0] FUNC_SPARE = 3'(FUNC_TICK + 1);
  localparam logic [2:0] REG_SPARE  = 3'(REG_GOAL_REGISTER + 1);

  logic clk = 1'b0;
  logic rst;

  logic        in_valid;
  logic        in_ready;
  logic [2:0]  func;
  logic [7:0]  servo_id;
  logic [7:0]  reg_addr;
  logic [7:0]  data_byte;
  logic [15:0] position;
  logic [7:0]  second_id;
  logic [15:0] second_position;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [7:0]  error_byte;
  logic        timed_out;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;

  int   fail_count;
  int   pending;
  logic idle;
  int   bytes_seen;
  int   outcomes_seen;
  int   timeouts_seen;

  int         items_sent  = 0;
  int         cfg_writes  = 0;
  int         burst_left  = 0;
  logic [7:0] cur_timeout = RST_TIMEOUT_TICKS;

  always #5 clk = ~clk;

  servo_bus_packet_master dut (.*);

  sbpm_packet_checker packet_check (.*);

  // Give up long after the slowest correct run would have finished.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: switch between drain patterns after spans of random length, so that
  // stalls land on every byte position of a packet and on the outcomes.
  initial begin
    drain_mode_t mode;
    int          span;
    int          stall_left;
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      mode = drain_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 80);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          DRAIN_FREE:   out_ready = 1'b1;
          DRAIN_COIN:   out_ready = 1'($urandom_range(0, 1));
          DRAIN_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
          default: begin
            // Hold ready low for a run of random length, then take one byte.
            out_ready = (stall_left == 0);
            if (stall_left == 0) stall_left = $urandom_range(1, 12);
            else stall_left--;
          end
        endcase
      end
    end
  end

  function automatic bus_item_t random_item(input logic [2:0] f);
    bus_item_t it;
    it.func = f;
    it.id   = 8'($urandom);
    it.addr = 8'($urandom);
    it.dat  = 8'($urandom);
    it.pos  = 16'($urandom);
    it.id2  = 8'($urandom);
    it.pos2 = 16'($urandom);
    it.rx   = 8'($urandom);
    return it;
  endfunction

  // Offer one item and hold it until taken. Items go out in bursts; at the end
  // of a burst drop valid for a random gap.
  task automatic offer_item(input bus_item_t it);
    @(negedge clk);
    in_valid        = 1'b1;
    func            = it.func;
    servo_id        = it.id;
    reg_addr        = it.addr;
    data_byte       = it.dat;
    position        = it.pos;
    second_id       = it.id2;
    second_position = it.pos2;
    rx_byte         = it.rx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic send_req(input logic [2:0] f);
    offer_item(random_item(f));
  endtask

  task automatic send_rx(input logic [7:0] b);
    bus_item_t it;
    it    = random_item(FUNC_RX_BYTE);
    it.rx = b;
    offer_item(it);
  endtask

  task automatic send_tick();
    offer_item(random_item(FUNC_TICK));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_writes++;
  endtask

  task automatic apply_setting(input logic [7:0] t, input logic [7:0] wop,
                               input logic [7:0] sop, input logic [7:0] pop,
                               input logic [7:0] goal);
    write_reg(REG_TIMEOUT_TICKS, t);
    write_reg(REG_WRITE_OPCODE, wop);
    write_reg(REG_SYNC_OPCODE, sop);
    write_reg(REG_PING_OPCODE, pop);
    write_reg(REG_GOAL_REGISTER, goal);
    cur_timeout = t;
  endtask

  // Drop valid and wait for the block to go quiet: nothing due and no reply
  // awaited. Should a reply wait linger with nothing due, tick it out. Then
  // hold off a while longer, since ticks and reply bytes leave no trace.
  task automatic settle();
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    forever begin
      @(negedge clk);
      if (idle) break;
      if (pending == 0) send_tick();
    end
    @(negedge clk);
    in_valid = 1'b0;
    repeat (32) @(negedge clk);
  endtask

  // Answer the armed request with a full six-byte status reply. Slip ticks in
  // between the bytes, never enough to run the budget out, sometimes exactly
  // one short of it; now and then throw in a request that must be dropped.
  task automatic answer(input logic [7:0] err);
    int cap;
    int n;
    for (int i = 0; i < 6; i++) begin
      cap = (cur_timeout >= 2) ? ((cur_timeout > 4) ? 3 : int'(cur_timeout) - 1) : 0;
      n   = $urandom_range(0, cap);
      if (cur_timeout >= 2 && cur_timeout <= 16 && $urandom_range(0, 9) == 0)
        n = int'(cur_timeout) - 1;
      repeat (n) send_tick();
      if ($urandom_range(0, 12) == 0) send_req(3'($urandom_range(0, 3)));
      send_rx((i == 4) ? err : 8'($urandom));
    end
  endtask

  // Broken reply: a few bytes, then enough ticks to run the budget out.
  task automatic lapse();
    int k;
    k = $urandom_range(0, 5);
    repeat (k) send_rx(8'($urandom));
    repeat ((cur_timeout <= 1) ? 1 : int'(cur_timeout)) send_tick();
  endtask

  // Items the block should ignore when no reply is awaited.
  task automatic noise_item();
    case ($urandom_range(0, 2))
      0:       send_tick();
      1:       send_rx(8'($urandom));
      default: send_req(3'(FUNC_SPARE + $urandom_range(0, 1)));
    endcase
  endtask

  // Mostly well-formed exchanges with random content, some noise and some
  // replies that never complete.
  task automatic run_phase(input int quota);
    int         start;
    logic [2:0] f;
    start = items_sent;
    while (items_sent - start < quota) begin
      if ($urandom_range(0, 99) < 12) begin
        noise_item();
      end else begin
        f = 3'($urandom_range(0, 3));
        send_req(f);
        if (f != FUNC_SYNC_WRITE) begin
          if (cur_timeout <= 16 && $urandom_range(0, 99) < 35) lapse();
          else answer(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
        end
      end
    end
  endtask

  initial begin
    bus_item_t it;

    // Drive every input to a known value before the first edge.
    rst             = 1'b1;
    in_valid        = 1'b0;
    func            = FUNC_TICK;
    servo_id        = '0;
    reg_addr        = '0;
    data_byte       = '0;
    position        = '0;
    second_id       = '0;
    second_position = '0;
    rx_byte         = '0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_TIMEOUT_TICKS;
    cfg_data        = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset register values first.
    it    = random_item(FUNC_PING);
    it.id = 8'h00;
    offer_item(it);
    answer(8'h00);

    it     = random_item(FUNC_WRITE_POS);
    it.id  = 8'hFF;
    it.pos = 16'hFFFF;
    offer_item(it);
    send_req(FUNC_PING);               // dropped: a reply is awaited
    answer(8'hFF);

    it      = random_item(FUNC_SYNC_WRITE);
    it.id   = 8'h00;
    it.pos  = 16'h0000;
    it.id2  = 8'hFF;
    it.pos2 = 16'hFFFF;
    offer_item(it);

    // Nothing awaited: a byte, a tick and the undefined codes all vanish.
    send_rx(8'($urandom));
    send_tick();
    send_req(FUNC_SPARE);
    send_req(3'(FUNC_SPARE + 1));

    // Tight budget: a byte reloads it, then two ticks run it out.
    settle();
    apply_setting(8'd2, 8'hFF, 8'h00, 8'h00, 8'hFF);
    it      = random_item(FUNC_WRITE_REG);
    it.addr = 8'hFF;
    it.dat  = 8'h00;
    offer_item(it);
    send_tick();
    send_rx(8'($urandom));
    send_tick();
    send_tick();
    send_rx(8'($urandom));             // dropped: the wait has ended

    // Random phases, each under its own register setting.
    settle();
    apply_setting(8'd1, 8'h00, 8'h00, 8'h00, 8'h00);
    write_reg(3'(REG_SPARE + $urandom_range(0, 2)), 8'($urandom));
    run_phase(28);

    settle();
    apply_setting(8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    run_phase(28);

    settle();
    apply_setting(8'd0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    run_phase(28);

    settle();
    apply_setting(8'($urandom_range(2, 12)), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom));
    write_reg(3'(REG_SPARE + $urandom_range(0, 2)), 8'($urandom));
    run_phase(28);

    settle();
    apply_setting(8'($urandom_range(2, 16)), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom));
    run_phase(28);

    settle();
    apply_setting(RST_TIMEOUT_TICKS, RST_WRITE_OPCODE, RST_SYNC_OPCODE,
                  RST_PING_OPCODE, RST_GOAL_REGISTER);
    run_phase(28);

    // Drain and let the block run dry before the verdict.
    settle();

    $display("Covered %0d items and %0d register writes over seven register settings.",
             items_sent, cfg_writes);
    $display("Checked %0d packet bytes and %0d reply outcomes, %0d of them timeouts.",
             bytes_seen, outcomes_seen, timeouts_seen);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/sbpm_pkg.sv
rtl/sbpm_front.sv
rtl/sbpm_queue.sv
rtl/sbpm_back.sv
rtl/servo_bus_packet_master.sv
tb/sv/sbpm_packet_checker.sv
tb/sv/tb.sv
